// ===== rtl/fcm_pkg.sv =====
// Shared constants, codes and widths for the free cell map.
`default_nettype none

package fcm_pkg;

  localparam int MAX_ROWS = 16;
  localparam int MAX_COLS = 16;

  localparam int ROW_W = $clog2(MAX_ROWS);
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int CNT_W = $clog2(MAX_COLS + 1);
  localparam int HGT_W = $clog2(MAX_ROWS + 1);
  localparam int TOT_W = $clog2(MAX_ROWS * MAX_COLS + 1);
  localparam int RANK_W = 8;
  localparam int CMP_W = (TOT_W > RANK_W) ? TOT_W : RANK_W;

  // Port field widths
  localparam int FUNC_W = 2;
  localparam int POS_W = 4;
  localparam int STATUS_W = 3;
  localparam int FREE_W = 9;
  localparam int DIM_W = 5;
  localparam int CFG_IDX_W = 4;

  typedef enum logic [FUNC_W-1:0] {
    FUNC_CLEAR = 2'd0,
    FUNC_MARK  = 2'd1,
    FUNC_PICK  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK          = 3'd0,
    ST_NOT_CLEARED = 3'd1,
    ST_OFF_BOARD   = 3'd2,
    ST_TAKEN       = 3'd3,
    ST_RANK        = 3'd4
  } status_t;

  localparam logic [CFG_IDX_W-1:0] REG_BOARD_WIDTH = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BOARD_HEIGHT = 4'd1;

endpackage

`default_nettype wire

// ===== rtl/fcm_req_if.sv =====
// Request channel: operation and its operands.
`default_nettype none

interface fcm_req_if import fcm_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [FUNC_W-1:0] func;
  logic [POS_W-1:0]  col;
  logic [POS_W-1:0]  row;
  logic [RANK_W-1:0] rank;

  modport source (output valid, func, col, row, rank, input ready);
  modport sink (input valid, func, col, row, rank, output ready);
endinterface

`default_nettype wire

// ===== rtl/fcm_rsp_if.sv =====
// Response channel: status, picked cell and remaining free count.
`default_nettype none

interface fcm_rsp_if import fcm_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [POS_W-1:0]    pick_col;
  logic [POS_W-1:0]    pick_row;
  logic [FREE_W-1:0]   free_count;

  modport source (output valid, status, pick_col, pick_row, free_count, input ready);
  modport sink (input valid, status, pick_col, pick_row, free_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/fcm_cfg_if.sv =====
// Configuration write channel.
`default_nettype none

interface fcm_cfg_if import fcm_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  logic [DIM_W-1:0]     data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/fcm_ram.sv =====
// Generic single write port, single read port RAM with registered read.
`default_nettype none

module fcm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

// ===== rtl/free_cell_map_rank_select.sv =====
// Free cell map with rank select: bitmap plus per-row counts in RAM, sequencer on top.
//
// The block tracks which cells of a board of up to MAX_ROWS x MAX_COLS are free.
// A clear (func 0) rebuilds the map from board_width / board_height: after the
// acceptance cycle, one row is written per cycle into both memories, the last
// row held until the response register is free. A mark (func 1) reads the row's
// bitmap and count on acceptance, then checks them and writes them back once the
// response register is free. A pick (func 2) walks the row-count memory one row
// per cycle until the row holding the requested rank is found, loads that row's
// bitmap, then scans it one column per cycle. Not-cleared, off-board and rank
// errors and func 3 are answered on acceptance; a taken cell shows in the mark check.
// The single read port per memory is why the walk reads one row count at a time.
// Before the first clear the memories hold nothing of meaning; marks and picks
// are refused with status "not cleared" until then, so reset runs no clearing pass.
// One response per request transaction; a finished response waits in an output
// register; a new request is taken in idle while that register is free or drains.
// Configuration writes are always ready and should come only while idle.
`default_nettype none

module free_cell_map_rank_select import fcm_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  fcm_req_if.sink   req,
  fcm_rsp_if.source rsp,
  fcm_cfg_if.sink   cfg
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_CLEAR = 5'b00010,
    S_MARK  = 5'b00100,
    S_WALK  = 5'b01000,
    S_SCAN  = 5'b10000
  } state_t;

  localparam logic [MAX_COLS-1:0] ONE_COL = MAX_COLS'(1);
  localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(MAX_ROWS - 1);

  // Configuration
  logic [DIM_W-1:0] board_width, board_height;
  logic [CNT_W-1:0] eff_w;
  logic [HGT_W-1:0] eff_h;

  // Sequencer state
  state_t state, state_next;
  logic [ROW_W-1:0] cur_row, cur_row_next;
  logic [COL_W-1:0] op_col, op_col_next;
  logic [COL_W-1:0] scan_col, scan_col_next;
  logic [CNT_W-1:0] seen, seen_next;
  logic [CNT_W-1:0] offset, offset_next;
  logic [CNT_W-1:0] row_cnt, row_cnt_next;
  logic [TOT_W-1:0] row_base, row_base_next;
  logic [RANK_W-1:0] rank_q, rank_q_next;
  logic [MAX_COLS-1:0] bits_q, bits_q_next;
  logic loaded, loaded_next;
  logic [TOT_W-1:0] total_free, total_free_next;
  logic ready_flag, ready_flag_next;

  // Memory ports
  logic bits_we, cnt_we;
  logic [ROW_W-1:0] bits_raddr, cnt_raddr;
  logic [MAX_COLS-1:0] bits_wdata, bits_rdata;
  logic [CNT_W-1:0] cnt_wdata, cnt_rdata;

  // Response
  logic can_emit, emit;
  status_t emit_status;
  logic [POS_W-1:0] emit_col, emit_row;
  logic [FREE_W-1:0] emit_free;
  logic out_valid;
  status_t out_status;
  logic [POS_W-1:0] out_col, out_row;
  logic [FREE_W-1:0] out_free;

  logic req_fire;
  logic [ROW_W-1:0] in_row_idx;
  logic [CMP_W-1:0] walk_sum;
  logic [MAX_COLS-1:0] clr_mask;
  logic [TOT_W-1:0] clr_total;

  // Registers above MAX are clamped
  assign eff_w = (32'(board_width) > 32'(MAX_COLS)) ? CNT_W'(MAX_COLS) : CNT_W'(board_width);
  assign eff_h = (32'(board_height) > 32'(MAX_ROWS)) ? HGT_W'(MAX_ROWS) : HGT_W'(board_height);

  always_comb begin
    for (int c = 0; c < MAX_COLS; c++) begin
      clr_mask[c] = (32'(c) < 32'(eff_w));
    end
  end

  assign clr_total = TOT_W'(eff_w) * TOT_W'(eff_h);

  assign can_emit = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && can_emit;
  assign req_fire = req.valid && req.ready;
  assign in_row_idx = ROW_W'(req.row);
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      board_width <= DIM_W'(15);
      board_height <= DIM_W'(15);
    end else if (cfg.valid) begin
      if (cfg.index == REG_BOARD_WIDTH) begin
        board_width <= cfg.data;
      end else if (cfg.index == REG_BOARD_HEIGHT) begin
        board_height <= cfg.data;
      end
    end
  end

  fcm_ram #(.WIDTH(MAX_COLS), .DEPTH(MAX_ROWS)) u_bits_ram (
    .clk   (clk),
    .we    (bits_we),
    .waddr (cur_row),
    .wdata (bits_wdata),
    .raddr (bits_raddr),
    .rdata (bits_rdata)
  );

  fcm_ram #(.WIDTH(CNT_W), .DEPTH(MAX_ROWS)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cur_row),
    .wdata (cnt_wdata),
    .raddr (cnt_raddr),
    .rdata (cnt_rdata)
  );

  always_comb begin
    state_next = state;
    cur_row_next = cur_row;
    op_col_next = op_col;
    scan_col_next = scan_col;
    seen_next = seen;
    offset_next = offset;
    row_cnt_next = row_cnt;
    row_base_next = row_base;
    rank_q_next = rank_q;
    bits_q_next = bits_q;
    loaded_next = loaded;
    total_free_next = total_free;
    ready_flag_next = ready_flag;

    bits_we = 1'b0;
    cnt_we = 1'b0;
    bits_wdata = bits_rdata;
    cnt_wdata = cnt_rdata;
    bits_raddr = cur_row;
    cnt_raddr = cur_row;

    emit = 1'b0;
    emit_status = ST_OK;
    emit_col = '0;
    emit_row = '0;
    emit_free = FREE_W'(total_free);

    walk_sum = CMP_W'(row_base) + CMP_W'(cnt_rdata);

    unique case (state)
      S_IDLE: begin
        bits_raddr = in_row_idx;
        cnt_raddr = (func_t'(req.func) == FUNC_PICK) ? '0 : in_row_idx;
        if (req_fire) begin
          unique case (func_t'(req.func))
            FUNC_CLEAR: begin
              cur_row_next = '0;
              state_next = S_CLEAR;
            end
            FUNC_MARK: begin
              if (!ready_flag) begin
                emit = 1'b1;
                emit_status = ST_NOT_CLEARED;
              end else if (32'(req.col) >= 32'(eff_w) || 32'(req.row) >= 32'(eff_h)) begin
                emit = 1'b1;
                emit_status = ST_OFF_BOARD;
              end else begin
                cur_row_next = in_row_idx;
                op_col_next = COL_W'(req.col);
                state_next = S_MARK;
              end
            end
            FUNC_PICK: begin
              if (!ready_flag) begin
                emit = 1'b1;
                emit_status = ST_NOT_CLEARED;
              end else if (CMP_W'(req.rank) >= CMP_W'(total_free)) begin
                emit = 1'b1;
                emit_status = ST_RANK;
              end else begin
                cur_row_next = '0;
                row_base_next = '0;
                rank_q_next = req.rank;
                state_next = S_WALK;
              end
            end
            FUNC_NOP: begin
              emit = 1'b1;
            end
            default: begin
              emit = 1'b1;
            end
          endcase
        end
      end

      // One row per cycle; stall on the last row until the response slot frees
      S_CLEAR: begin
        bits_we = 1'b1;
        cnt_we = 1'b1;
        if (32'(cur_row) < 32'(eff_h)) begin
          bits_wdata = clr_mask;
          cnt_wdata = eff_w;
        end else begin
          bits_wdata = '0;
          cnt_wdata = '0;
        end
        if (cur_row == LAST_ROW) begin
          if (can_emit) begin
            emit = 1'b1;
            emit_free = FREE_W'(clr_total);
            total_free_next = clr_total;
            ready_flag_next = 1'b1;
            state_next = S_IDLE;
          end
        end else begin
          cur_row_next = ROW_W'(cur_row + 1'b1);
        end
      end

      S_MARK: begin
        if (can_emit) begin
          emit = 1'b1;
          state_next = S_IDLE;
          if (!bits_rdata[op_col]) begin
            emit_status = ST_TAKEN;
          end else begin
            bits_we = 1'b1;
            cnt_we = 1'b1;
            bits_wdata = bits_rdata & ~(ONE_COL << op_col);
            cnt_wdata = cnt_rdata - CNT_W'(1);
            total_free_next = total_free - TOT_W'(1);
            emit_free = FREE_W'(total_free - TOT_W'(1));
          end
        end
      end

      // cnt_rdata holds the count of cur_row; prefetch the next row meanwhile
      S_WALK: begin
        if (CMP_W'(rank_q) < walk_sum) begin
          offset_next = CNT_W'(CMP_W'(rank_q) - CMP_W'(row_base));
          row_cnt_next = cnt_rdata;
          loaded_next = 1'b0;
          state_next = S_SCAN;
        end else begin
          row_base_next = TOT_W'(walk_sum);
          cur_row_next = ROW_W'(cur_row + 1'b1);
          cnt_raddr = ROW_W'(cur_row + 1'b1);
        end
      end

      // First cycle loads the row bitmap, then one column per cycle
      S_SCAN: begin
        if (!loaded) begin
          bits_q_next = bits_rdata;
          scan_col_next = '0;
          seen_next = '0;
          loaded_next = 1'b1;
        end else if (bits_q[scan_col]) begin
          if (seen == offset) begin
            if (can_emit) begin
              bits_we = 1'b1;
              cnt_we = 1'b1;
              bits_wdata = bits_q & ~(ONE_COL << scan_col);
              cnt_wdata = row_cnt - CNT_W'(1);
              total_free_next = total_free - TOT_W'(1);
              emit = 1'b1;
              emit_col = POS_W'(scan_col);
              emit_row = POS_W'(cur_row);
              emit_free = FREE_W'(total_free - TOT_W'(1));
              state_next = S_IDLE;
            end
          end else begin
            seen_next = seen + CNT_W'(1);
            scan_col_next = COL_W'(scan_col + 1'b1);
          end
        end else begin
          scan_col_next = COL_W'(scan_col + 1'b1);
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      total_free <= '0;
      ready_flag <= 1'b0;
      loaded <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      total_free <= total_free_next;
      ready_flag <= ready_flag_next;
      loaded <= loaded_next;
      if (emit) begin
        out_valid <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cur_row <= cur_row_next;
    op_col <= op_col_next;
    scan_col <= scan_col_next;
    seen <= seen_next;
    offset <= offset_next;
    row_cnt <= row_cnt_next;
    row_base <= row_base_next;
    rank_q <= rank_q_next;
    bits_q <= bits_q_next;
    if (emit) begin
      out_status <= emit_status;
      out_col <= emit_col;
      out_row <= emit_row;
      out_free <= emit_free;
    end
  end

  assign rsp.valid = out_valid;
  assign rsp.status = out_status;
  assign rsp.pick_col = out_col;
  assign rsp.pick_row = out_row;
  assign rsp.free_count = out_free;

endmodule

`default_nettype wire

// ===== tb/fcm_map_checker.sv =====
// Checker for the free cell map: predicts each response and compares it field by field.
`timescale 1ns / 1ps

module fcm_map_checker import fcm_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  fcm_req_if                req,
  fcm_rsp_if                rsp,
  fcm_cfg_if                cfg,
  output int                errors,
  output int                outstanding,
  output logic [FREE_W-1:0] free_hint
);

  typedef struct packed {
    status_t             status;
    logic [POS_W-1:0]    col;
    logic [POS_W-1:0]    row;
    logic [FREE_W-1:0]   free;
  } map_answer_t;

  logic [MAX_COLS-1:0] cell_free [MAX_ROWS];
  logic [CNT_W-1:0]    row_free [MAX_ROWS];
  logic [FREE_W-1:0]   free_total;
  logic                map_ready;
  logic [DIM_W-1:0]    board_cols;
  logic [DIM_W-1:0]    board_rows;

  map_answer_t awaited_answers [$];

  function automatic int clamp_dim(logic [DIM_W-1:0] v, int lim);
    return (v > lim) ? lim : int'(v);
  endfunction

  function automatic void take_cell(logic [POS_W-1:0] r, logic [POS_W-1:0] c);
    cell_free[r][c] = 1'b0;
    row_free[r] = row_free[r] - 1'b1;
    free_total = free_total - 1'b1;
  endfunction

  // Applies one transaction to the shadow map and returns the answer it should give.
  function automatic map_answer_t apply_map_op(func_t f, logic [POS_W-1:0] c,
                                               logic [POS_W-1:0] r, logic [RANK_W-1:0] k);
    map_answer_t a;
    int w;
    int h;
    int base;
    int seen;
    bit row_hit;
    bit done;
    a = '0;
    a.status = ST_OK;
    w = clamp_dim(board_cols, MAX_COLS);
    h = clamp_dim(board_rows, MAX_ROWS);
    base = 0;
    seen = 0;
    row_hit = 1'b0;
    done = 1'b0;
    case (f)
      FUNC_CLEAR: begin
        free_total = '0;
        for (int y = 0; y < MAX_ROWS; y++) begin
          cell_free[y] = '0;
          row_free[y] = '0;
          if (y < h) begin
            for (int x = 0; x < w; x++) cell_free[y][x] = 1'b1;
            row_free[y] = CNT_W'(w);
            free_total = free_total + FREE_W'(w);
          end
        end
        map_ready = 1'b1;
      end
      FUNC_MARK: begin
        if (!map_ready) a.status = ST_NOT_CLEARED;
        else if (c >= w || r >= h) a.status = ST_OFF_BOARD;
        else if (!cell_free[r][c]) a.status = ST_TAKEN;
        else take_cell(r, c);
      end
      FUNC_PICK: begin
        if (!map_ready) a.status = ST_NOT_CLEARED;
        else if (k >= free_total) a.status = ST_RANK;
        else begin
          // skip whole rows by count, then count free cells within the row
          for (int y = 0; y < MAX_ROWS && !done; y++) begin
            if (k < base + row_free[y]) begin
              done = 1'b1;
              for (int x = 0; x < MAX_COLS && !row_hit; x++) begin
                if (cell_free[y][x]) begin
                  if (seen == k - base) begin
                    row_hit = 1'b1;
                    a.col = POS_W'(x);
                    a.row = POS_W'(y);
                  end
                  seen++;
                end
              end
            end else begin
              base += row_free[y];
            end
          end
          if (row_hit) take_cell(a.row, a.col);
          else a.status = ST_RANK;
        end
      end
      default: ;
    endcase
    a.free = free_total;
    return a;
  endfunction

  task automatic report(string what, int got, int want);
    $display("%0t: mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    errors++;
  endtask

  always @(posedge clk) begin
    map_answer_t want;
    map_answer_t got;
    if (rst) begin
      for (int y = 0; y < MAX_ROWS; y++) begin
        cell_free[y] = '0;
        row_free[y] = '0;
      end
      free_total = '0;
      map_ready = 1'b0;
      board_cols = 5'd15;
      board_rows = 5'd15;
      awaited_answers.delete();
      errors = 0;
      outstanding <= 0;
      free_hint <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        case (cfg.index)
          REG_BOARD_WIDTH:  board_cols = cfg.data;
          REG_BOARD_HEIGHT: board_rows = cfg.data;
          default: ;
        endcase
      end
      if (req.valid && req.ready)
        awaited_answers = {awaited_answers,
                           apply_map_op(func_t'(req.func), req.col, req.row, req.rank)};
      if (rsp.valid && rsp.ready) begin
        got.status = status_t'(rsp.status);
        got.col = rsp.pick_col;
        got.row = rsp.pick_row;
        got.free = rsp.free_count;
        if (awaited_answers.size() == 0) begin
          report("unexpected response, status", got.status, -1);
        end else begin
          want = awaited_answers.pop_front();
          if (got.status != want.status) report("status", got.status, want.status);
          if (got.col != want.col) report("pick_col", got.col, want.col);
          if (got.row != want.row) report("pick_row", got.row, want.row);
          if (got.free != want.free) report("free_count", got.free, want.free);
        end
      end
      outstanding <= awaited_answers.size();
      free_hint <= free_total;
    end
  end

endmodule

// ===== tb/free_cell_map_rank_select_test.sv =====
// Top of the free cell map test: clock, reset, stimulus, response back-pressure and verdict.
`timescale 1ns / 1ps

module free_cell_map_rank_select_test;
  import fcm_pkg::*;

  localparam int IDLE_LIMIT = 2000;   // cycles with no transaction anywhere
  localparam int PHASES = 9;
  localparam int FIXED_PHASES = 7;
  localparam int OPS_PER_PHASE = 64;
  localparam int TAIL_CYCLES = 40;
  // index outside the register file; the block must ignore the write
  localparam logic [CFG_IDX_W-1:0] REG_SPARE = 4'hF;

  logic clk;
  logic rst;

  fcm_req_if req_ch();
  fcm_rsp_if rsp_ch();
  fcm_cfg_if cfg_ch();

  int                errors;
  int                outstanding;
  logic [FREE_W-1:0] free_hint;

  int gap_pct;       // chance of a sender gap before a request
  int stall_pct;     // chance of a response stall per cycle
  bit calm;          // no idling at all in the closing part
  int idle_cycles;
  int cols_eff;      // board size as the block sees it, for aiming marks
  int rows_eff;

  free_cell_map_rank_select u_top (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch)
  );

  fcm_map_checker u_check (
    .clk(clk),
    .rst(rst),
    .req(req_ch),
    .rsp(rsp_ch),
    .cfg(cfg_ch),
    .errors(errors),
    .outstanding(outstanding),
    .free_hint(free_hint)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Response side: ready drops in short random bursts unless in the calm tail.
  initial begin
    rsp_ch.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 5)) @(posedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
    end
  end

  // Watchdog: any transaction on any channel restarts the count.
  always @(posedge clk) begin
    if (rst || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    @(posedge clk);
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("free_cell_map_rank_select verification failed");
    $finish;
  end

  // One request transaction. Called at a rising edge; returns at the edge that
  // accepts it, with valid still high so the next request can follow directly.
  task automatic issue(func_t f, logic [POS_W-1:0] c, logic [POS_W-1:0] r,
                       logic [RANK_W-1:0] k);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
    end
    req_ch.valid <= 1'b1;
    req_ch.func <= f;
    req_ch.col <= c;
    req_ch.row <= r;
    req_ch.rank <= k;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
  endtask

  // Stop sending and wait until every predicted response has come back.
  // The extra edge lets the checker count the request accepted last.
  task automatic settle();
    req_ch.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // Register write; only ever called with the block idle.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [DIM_W-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_board(logic [DIM_W-1:0] w, logic [DIM_W-1:0] h);
    write_reg(REG_BOARD_WIDTH, w);
    write_reg(REG_BOARD_HEIGHT, h);
    cols_eff = (w > MAX_COLS) ? MAX_COLS : int'(w);
    rows_eff = (h > MAX_ROWS) ? MAX_ROWS : int'(h);
  endtask

  initial begin
    int phase_w [FIXED_PHASES];
    int phase_h [FIXED_PHASES];
    int sel;
    int hint;
    logic [DIM_W-1:0] w;
    logic [DIM_W-1:0] h;
    logic [POS_W-1:0] c;
    logic [POS_W-1:0] r;

    phase_w = '{16, 15, 1, 16, 7, 31, 0};
    phase_h = '{16, 15, 16, 1, 5, 20, 9};
    rst <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.func <= FUNC_CLEAR;
    req_ch.col <= '0;
    req_ch.row <= '0;
    req_ch.rank <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_BOARD_WIDTH;
    cfg_ch.data <= '0;
    calm = 1'b0;
    gap_pct = 20;
    stall_pct = 20;
    cols_eff = 15;
    rows_eff = 15;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // --- directed: reset geometry 15 x 15 ---
    issue(FUNC_MARK, 4'd0, 4'd0, 8'd0);       // refused: no clear yet
    issue(FUNC_PICK, 4'd15, 4'd15, 8'd255);   // refused: no clear yet
    issue(FUNC_NOP, 4'd15, 4'd15, 8'd255);    // unused code, nothing changes
    issue(FUNC_CLEAR, 4'd0, 4'd0, 8'd0);
    issue(FUNC_MARK, 4'd0, 4'd0, 8'd0);
    issue(FUNC_MARK, 4'd0, 4'd0, 8'd0);       // already taken
    issue(FUNC_MARK, 4'd14, 4'd14, 8'd0);     // far corner
    issue(FUNC_MARK, 4'd15, 4'd3, 8'd0);      // column just off the board
    issue(FUNC_MARK, 4'd3, 4'd15, 8'd0);      // row just off the board
    issue(FUNC_PICK, 4'd0, 4'd0, 8'd0);       // first free cell
    issue(FUNC_PICK, 4'd0, 4'd0, 8'd221);     // last free cell
    issue(FUNC_PICK, 4'd0, 4'd0, 8'd221);     // rank now equals the free count
    issue(FUNC_PICK, 4'd0, 4'd0, 8'd255);
    issue(FUNC_CLEAR, 4'd0, 4'd0, 8'd0);      // rebuild, not add

    // full 16 x 16 board: free count reaches 256
    settle();
    set_board(5'd16, 5'd16);
    issue(FUNC_CLEAR, 4'd0, 4'd0, 8'd0);
    issue(FUNC_PICK, 4'd0, 4'd0, 8'd255);
    issue(FUNC_MARK, 4'd15, 4'd15, 8'd0);

    // zero width: empty board after clear
    settle();
    set_board(5'd0, 5'd16);
    issue(FUNC_CLEAR, 4'd0, 4'd0, 8'd0);
    issue(FUNC_PICK, 4'd0, 4'd0, 8'd0);
    issue(FUNC_MARK, 4'd0, 4'd0, 8'd0);

    // oversize registers clamp to the full grid
    settle();
    set_board(5'd31, 5'd17);
    issue(FUNC_CLEAR, 4'd0, 4'd0, 8'd0);

    // single cell board, plus a write to an unused index
    settle();
    set_board(5'd1, 5'd1);
    write_reg(REG_SPARE, 5'd31);
    issue(FUNC_CLEAR, 4'd0, 4'd0, 8'd0);
    issue(FUNC_PICK, 4'd0, 4'd0, 8'd0);
    issue(FUNC_PICK, 4'd0, 4'd0, 8'd0);
    issue(FUNC_MARK, 4'd0, 4'd0, 8'd0);

    // --- random phases, each on its own geometry ---
    for (int p = 0; p < PHASES; p++) begin
      settle();
      if (p < FIXED_PHASES) begin
        w = DIM_W'(phase_w[p]);
        h = DIM_W'(phase_h[p]);
      end else begin
        w = DIM_W'($urandom_range(0, 31));
        h = DIM_W'($urandom_range(0, 31));
      end
      set_board(w, h);
      // vary idling so some phases run with none
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 25;
        default: gap_pct = 50;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 25;
        default: stall_pct = 50;
      endcase
      calm = (p == PHASES - 1);
      issue(FUNC_CLEAR, 4'd0, 4'd0, 8'd0);

      for (int n = 0; n < OPS_PER_PHASE; n++) begin
        // hold off once mid-run until the block has answered everything
        if (p == 3 && n == OPS_PER_PHASE / 2) settle();
        hint = free_hint;   // may trail by one transaction; a stray rank error is fine
        sel = $urandom_range(0, 99);
        c = POS_W'($urandom_range(0, 15));
        r = POS_W'($urandom_range(0, 15));
        if (cols_eff > 0 && rows_eff > 0) begin
          if (sel >= 55 && sel < 90) begin
            c = POS_W'($urandom_range(0, cols_eff - 1));
            r = POS_W'($urandom_range(0, rows_eff - 1));
          end
        end
        if (sel < 3 || (hint == 0 && sel < 80)) begin
          issue(FUNC_CLEAR, c, r, RANK_W'($urandom_range(0, 255)));
        end else if (sel < 5) begin
          issue(FUNC_NOP, c, r, RANK_W'($urandom_range(0, 255)));
        end else if (sel < 50) begin
          issue(FUNC_PICK, c, r, RANK_W'(hint > 0 ? $urandom_range(0, hint - 1) : 0));
        end else if (sel < 52) begin
          // boundary ranks: the last free cell, and one past it
          issue(FUNC_PICK, c, r, RANK_W'(hint > 0 ? hint - $urandom_range(0, 1) : 0));
        end else if (sel < 55) begin
          issue(FUNC_PICK, c, r, RANK_W'($urandom_range(0, 255)));
        end else begin
          issue(FUNC_MARK, c, r, RANK_W'($urandom_range(0, 255)));
        end
      end
    end

    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0 && outstanding == 0) begin
      $display("free_cell_map_rank_select verification clean");
    end else begin
      $display("free_cell_map_rank_select verification failed");
    end
    $finish;
  end

endmodule

// ===== free_cell_map_rank_select.f =====
rtl/fcm_pkg.sv
rtl/fcm_req_if.sv
rtl/fcm_rsp_if.sv
rtl/fcm_cfg_if.sv
rtl/fcm_ram.sv
rtl/free_cell_map_rank_select.sv
tb/fcm_map_checker.sv
tb/free_cell_map_rank_select_test.sv
